>>> src/glu_pkg.sv
// shared types, codes and constants of the grid field lookup
package glu_pkg;

  localparam int LON_MAX_CELLS_DEF = 256;
  localparam int LAT_MAX_CELLS_DEF = 128;
  localparam int WEIGHT_BITS_DEF   = 12;

  // quotient bits resolved per divider stage
  localparam int DIV_STEP = 4;

  localparam logic [1:0] KIND_WRITE    = 2'd0;
  localparam logic [1:0] KIND_NEAREST  = 2'd1;
  localparam logic [1:0] KIND_BILINEAR = 2'd2;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_LON = 2'd1;
  localparam logic [1:0] ST_LAT = 2'd2;

  localparam logic [2:0] REG_LON_ORIGIN  = 3'd0;
  localparam logic [2:0] REG_LON_SPACING = 3'd1;
  localparam logic [2:0] REG_LON_CELLS   = 3'd2;
  localparam logic [2:0] REG_LAT_ORIGIN  = 3'd3;
  localparam logic [2:0] REG_LAT_SPACING = 3'd4;
  localparam logic [2:0] REG_LAT_CELLS   = 3'd5;

  localparam logic [15:0] LON_ORIGIN_RST  = 16'd0;
  localparam logic [15:0] LON_SPACING_RST = 16'd256;
  localparam logic [8:0]  LON_CELLS_RST   = 9'd256;
  localparam logic [15:0] LAT_ORIGIN_RST  = 16'hC000;
  localparam logic [15:0] LAT_SPACING_RST = 16'd256;
  localparam logic [7:0]  LAT_CELLS_RST   = 8'd128;

  typedef struct packed {
    logic [1:0]         kind;
    logic [15:0]        longitude;
    logic signed [15:0] latitude;
    logic [7:0]         column;
    logic [6:0]         row;
    logic signed [15:0] sample;
  } in_t;

  typedef struct packed {
    logic signed [15:0] value;
    logic [1:0]         status;
  } out_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [1:0] status;
  } ctl_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [7:0]         column;
    logic [6:0]         row;
    logic signed [15:0] sample;
    logic               o_neg;
    logic               t_neg;
    logic               lon_wrap;
  } side_t;

endpackage

>>> src/grid_field_bilinear_lookup.sv
// top level: config registers, stage control, index checks and grid banks
// throughput: one item per cycle unless a stalled result backs up the pipeline;
// the divider resolves 4 quotient bits per stage
// and four single-port banks (row parity, two column copies) serve all corners at once
// reset: config registers to defaults and pipeline emptied; grid contents
// are undefined until written
module grid_field_bilinear_lookup import glu_pkg::*; #(
  parameter int LON_MAX_CELLS = LON_MAX_CELLS_DEF,
  parameter int LAT_MAX_CELLS = LAT_MAX_CELLS_DEF,
  parameter int WEIGHT_BITS   = WEIGHT_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_t         in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_t        out_data_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int QW   = 16 + WEIGHT_BITS;
  localparam int NST  = (QW + DIV_STEP - 1) / DIV_STEP;
  localparam int SE   = NST;
  localparam int SM   = NST + 1;
  localparam int SB   = NST + 2;
  localparam int NS   = NST + 6;
  localparam int HR   = (LAT_MAX_CELLS + 1) / 2;
  localparam int DEPTH = LON_MAX_CELLS * HR;
  localparam int AW   = $clog2(DEPTH);
  localparam int CW   = $clog2(LON_MAX_CELLS);
  localparam int RW   = $clog2(LAT_MAX_CELLS);
  localparam int HRW  = (HR > 1) ? $clog2(HR) : 1;
  localparam logic [QW:0] HALFQ = (QW+1)'(1) << (WEIGHT_BITS - 1);

  // config registers
  logic [15:0] lon_origin_q, lon_spacing_q, lat_origin_q, lat_spacing_q;
  logic [8:0]  lon_cells_q;
  logic [7:0]  lat_cells_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lon_origin_q  <= LON_ORIGIN_RST;
      lon_spacing_q <= LON_SPACING_RST;
      lon_cells_q   <= LON_CELLS_RST;
      lat_origin_q  <= LAT_ORIGIN_RST;
      lat_spacing_q <= LAT_SPACING_RST;
      lat_cells_q   <= LAT_CELLS_RST;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        REG_LON_ORIGIN:  lon_origin_q  <= pwdata[15:0];
        REG_LON_SPACING: lon_spacing_q <= pwdata[15:0];
        REG_LON_CELLS:   lon_cells_q   <= pwdata[8:0];
        REG_LAT_ORIGIN:  lat_origin_q  <= pwdata[15:0];
        REG_LAT_SPACING: lat_spacing_q <= pwdata[15:0];
        REG_LAT_CELLS:   lat_cells_q   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_LON_ORIGIN:  prdata = {16'd0, lon_origin_q};
      REG_LON_SPACING: prdata = {16'd0, lon_spacing_q};
      REG_LON_CELLS:   prdata = {23'd0, lon_cells_q};
      REG_LAT_ORIGIN:  prdata = {16'd0, lat_origin_q};
      REG_LAT_SPACING: prdata = {16'd0, lat_spacing_q};
      REG_LAT_CELLS:   prdata = {24'd0, lat_cells_q};
      default:         prdata = '0;
    endcase
  end

  // stage control: a stage loads when empty or when its successor moves
  logic [NS-1:0] vld_q, rdy;

  always_comb begin
    rdy[NS-1] = !vld_q[NS-1] || !out_stall_i;
    for (int k = NS - 2; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) begin
        vld_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NS; k++) begin
        if (rdy[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  assign in_stall_o  = !rdy[0];
  assign out_valid_o = vld_q[NS-1];

  // offsets from the grid origin
  logic [15:0]        d;
  logic signed [16:0] o;
  logic signed [18:0] t;
  logic [16:0]        dws;
  side_t              side_in, side_dv;
  logic [QW-1:0]      qlon, qlat;

  always_comb begin
    d   = in_data_i.longitude - lon_origin_q;
    o   = 17'(in_data_i.latitude) - 17'($signed(lat_origin_q));
    t   = {o[16], o, 1'b0} + {3'd0, lat_spacing_q};
    dws = {1'b0, d} + {1'b0, lon_spacing_q};
    side_in.kind     = in_data_i.kind;
    side_in.column   = in_data_i.column;
    side_in.row      = in_data_i.row;
    side_in.sample   = in_data_i.sample;
    side_in.o_neg    = o[16];
    side_in.t_neg    = t[18];
    side_in.lon_wrap = dws[16];
  end

  glu_div #(
    .WEIGHT_BITS(WEIGHT_BITS)
  ) u_div (
    .clk_i  (clk_i),
    .en_i   (rdy[NST-1:0]),
    .lon_x_i(d),
    .lon_s_i(lon_spacing_q),
    .lat_x_i(o[16] ? 16'd0 : o[15:0]),
    .lat_s_i(lat_spacing_q),
    .side_i (side_in),
    .lon_q_o(qlon),
    .lat_q_o(qlat),
    .side_o (side_dv)
  );

  // index checks and bank addressing
  logic [16:0]   ncol, nrow, i1, i2, ci, j1, j2, ri, rrow;
  logic [QW:0]   qlon_r, qlat_r;
  logic [1:0]    st;
  logic [CW-1:0] c_a, c_b;
  logic [RW-1:0] rbase;
  logic [RW:0]   rb1;
  logic [HRW-1:0] h_e, h_o;
  logic          wr_ok;
  logic [AW-1:0] waddr;
  logic [3:0]    bwe_d;
  logic [AW-1:0] badr_d [4];

  function automatic logic [AW-1:0] addr_of(input logic [CW-1:0] c, input logic [HRW-1:0] h);
    addr_of = AW'(int'(c) * HR + int'(h));
  endfunction

  always_comb begin
    ncol   = (17'(lon_cells_q) < 17'(LON_MAX_CELLS)) ? 17'(lon_cells_q) : 17'(LON_MAX_CELLS);
    nrow   = (17'(lat_cells_q) < 17'(LAT_MAX_CELLS)) ? 17'(lat_cells_q) : 17'(LAT_MAX_CELLS);
    i1     = {1'b0, qlon[QW-1:WEIGHT_BITS]};
    j1     = {1'b0, qlat[QW-1:WEIGHT_BITS]};
    i2     = i1 + 17'd1;
    j2     = j1 + 17'd1;
    qlon_r = {1'b0, qlon} + HALFQ;
    qlat_r = {1'b0, qlat} + HALFQ;
    ci     = qlon_r[QW:WEIGHT_BITS];
    ri     = qlat_r[QW:WEIGHT_BITS];
    rrow   = side_dv.o_neg ? 17'd0 : ri;

    st = ST_OK;
    case (side_dv.kind)
      KIND_NEAREST: begin
        if (lon_spacing_q == '0 || ci >= ncol) begin
          st = ST_LON;
        end else if (lat_spacing_q == '0 || side_dv.t_neg || rrow >= nrow) begin
          st = ST_LAT;
        end
      end
      KIND_BILINEAR: begin
        if (lon_spacing_q == '0 || i1 >= ncol) begin
          st = ST_LON;
        end else if (i2 >= ncol && !side_dv.lon_wrap) begin
          st = ST_LON;
        end else if (lat_spacing_q == '0 || side_dv.o_neg || j2 >= nrow) begin
          st = ST_LAT;
        end
      end
      default: st = ST_OK;
    endcase

    c_a   = (side_dv.kind == KIND_NEAREST) ? CW'(ci) : CW'(i1);
    c_b   = (i2 >= ncol) ? '0 : CW'(i2);
    rbase = (side_dv.kind == KIND_NEAREST) ? RW'(rrow) : RW'(j1);
    rb1   = {1'b0, rbase} + (RW+1)'(1);
    h_e   = HRW'(rb1 >> 1);
    h_o   = HRW'(rbase >> 1);

    wr_ok = (side_dv.kind == KIND_WRITE) && (int'(side_dv.column) < LON_MAX_CELLS)
            && (int'(side_dv.row) < LAT_MAX_CELLS);
    waddr = AW'(int'(side_dv.column) * HR + int'(side_dv.row >> 1));

    for (int b = 0; b < 4; b++) begin
      bwe_d[b] = wr_ok && (side_dv.row[0] == b[0]);
    end
    badr_d[0] = bwe_d[0] ? waddr : addr_of(c_a, h_e);
    badr_d[1] = bwe_d[1] ? waddr : addr_of(c_a, h_o);
    badr_d[2] = bwe_d[2] ? waddr : addr_of(c_b, h_e);
    badr_d[3] = bwe_d[3] ? waddr : addr_of(c_b, h_o);
  end

  ctl_t                   e_ctl_q, m_ctl_q;
  logic                   e_rpar_q, m_rpar_q;
  logic [WEIGHT_BITS-1:0] e_p_q, e_q_q, m_p_q, m_q_q;
  logic [3:0]             e_bwe_q;
  logic [AW-1:0]          e_badr_q [4];
  logic [15:0]            e_wdata_q;
  logic [15:0]            rd [4];

  always_ff @(posedge clk_i) begin
    if (rdy[SE]) begin
      e_ctl_q.kind   <= side_dv.kind;
      e_ctl_q.status <= st;
      e_rpar_q       <= rbase[0];
      e_p_q          <= qlon[WEIGHT_BITS-1:0];
      e_q_q          <= qlat[WEIGHT_BITS-1:0];
      e_bwe_q        <= bwe_d;
      e_badr_q       <= badr_d;
      e_wdata_q      <= side_dv.sample;
    end
  end

  // banks: 0 even rows at i1, 1 odd rows at i1, 2 even rows at i2, 3 odd rows at i2
  for (genvar b = 0; b < 4; b++) begin : g_bank
    glu_bank #(
      .DEPTH(DEPTH)
    ) u_bank (
      .clk_i  (clk_i),
      .en_i   (rdy[SM]),
      .we_i   (e_bwe_q[b] && vld_q[SE]),
      .addr_i (e_badr_q[b]),
      .wdata_i(e_wdata_q),
      .rdata_o(rd[b])
    );
  end

  always_ff @(posedge clk_i) begin
    if (rdy[SM]) begin
      m_ctl_q  <= e_ctl_q;
      m_rpar_q <= e_rpar_q;
      m_p_q    <= e_p_q;
      m_q_q    <= e_q_q;
    end
  end

  glu_blend #(
    .WEIGHT_BITS(WEIGHT_BITS)
  ) u_blend (
    .clk_i   (clk_i),
    .en_i    (rdy[NS-1:SB]),
    .ctl_i   (m_ctl_q),
    .rpar_i  (m_rpar_q),
    .rd_i    (rd),
    .p_i     (m_p_q),
    .q_i     (m_q_q),
    .value_o (out_data_o.value),
    .status_o(out_data_o.status)
  );

endmodule

>>> src/glu_div.sv
// pipelined restoring divider, longitude and latitude lanes side by side
module glu_div import glu_pkg::*; #(
  parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic [((16+WEIGHT_BITS+DIV_STEP-1)/DIV_STEP)-1:0] en_i,
  input  logic [15:0]               lon_x_i,
  input  logic [15:0]               lon_s_i,
  input  logic [15:0]               lat_x_i,
  input  logic [15:0]               lat_s_i,
  input  side_t                     side_i,
  output logic [16+WEIGHT_BITS-1:0] lon_q_o,
  output logic [16+WEIGHT_BITS-1:0] lat_q_o,
  output side_t                     side_o
);

  localparam int QW  = 16 + WEIGHT_BITS;
  localparam int NST = (QW + DIV_STEP - 1) / DIV_STEP;

  logic [15:0]   x [2];
  logic [15:0]   s [2];
  logic [15:0]   rem_q [2][NST];
  logic [QW-1:0] acc_q [2][NST];
  side_t         side_q [NST];

  assign x[0] = lon_x_i;
  assign x[1] = lat_x_i;
  assign s[0] = lon_s_i;
  assign s[1] = lat_s_i;

  for (genvar l = 0; l < 2; l++) begin : g_lane
    for (genvar k = 0; k < NST; k++) begin : g_st
      localparam int NB = (QW - k * DIV_STEP < DIV_STEP) ? QW - k * DIV_STEP : DIV_STEP;
      logic [15:0]   rem_in, rem_d;
      logic [QW-1:0] acc_in, acc_d;
      logic [16:0]   trial;

      if (k == 0) begin : g_first
        assign rem_in = '0;
        assign acc_in = {x[l], {WEIGHT_BITS{1'b0}}};
      end else begin : g_next
        assign rem_in = rem_q[l][k-1];
        assign acc_in = acc_q[l][k-1];
      end

      always_comb begin
        rem_d = rem_in;
        acc_d = acc_in;
        trial = '0;
        for (int b = 0; b < NB; b++) begin
          trial = {rem_d, acc_d[QW-1]};
          acc_d = {acc_d[QW-2:0], 1'b0};
          if (trial >= {1'b0, s[l]}) begin
            rem_d    = 16'(trial - {1'b0, s[l]});
            acc_d[0] = 1'b1;
          end else begin
            rem_d = trial[15:0];
          end
        end
      end

      always_ff @(posedge clk_i) begin
        if (en_i[k]) begin
          rem_q[l][k] <= rem_d;
          acc_q[l][k] <= acc_d;
        end
      end
    end
  end

  for (genvar k = 0; k < NST; k++) begin : g_side
    if (k == 0) begin : g_first
      always_ff @(posedge clk_i) begin
        if (en_i[k]) begin
          side_q[k] <= side_i;
        end
      end
    end else begin : g_next
      always_ff @(posedge clk_i) begin
        if (en_i[k]) begin
          side_q[k] <= side_q[k-1];
        end
      end
    end
  end

  assign lon_q_o = acc_q[0][NST-1];
  assign lat_q_o = acc_q[1][NST-1];
  assign side_o  = side_q[NST-1];

endmodule

>>> src/glu_bank.sv
// single-port grid sample bank with registered read
module glu_bank import glu_pkg::*; #(
  parameter int DEPTH = LON_MAX_CELLS_DEF * LAT_MAX_CELLS_DEF / 2
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [15:0]              wdata_i,
  output logic [15:0]              rdata_o
);

  logic [15:0] mem [DEPTH];
  logic [15:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/glu_blend.sv
// corner weighting, products, adder tree, rounding and output register
module glu_blend import glu_pkg::*; #(
  parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic [3:0]             en_i,
  input  ctl_t                   ctl_i,
  input  logic                   rpar_i,
  input  logic [15:0]            rd_i [4],
  input  logic [WEIGHT_BITS-1:0] p_i,
  input  logic [WEIGHT_BITS-1:0] q_i,
  output logic signed [15:0]     value_o,
  output logic [1:0]             status_o
);

  localparam int WW = 2 * WEIGHT_BITS + 2;
  localparam int PW = WW + 17;
  localparam int TW = PW + 2;
  localparam logic [WEIGHT_BITS:0] ONE = (WEIGHT_BITS+1)'(1) << WEIGHT_BITS;
  localparam logic signed [TW-1:0] HALF = TW'(1) << (2 * WEIGHT_BITS - 1);
  localparam logic signed [TW-1:0] VMAX = TW'(32767);
  localparam logic signed [TW-1:0] VMIN = TW'(-32768);

  logic [WEIGHT_BITS:0] pn, qn, pw, qw;
  logic signed [15:0]   g [4];

  ctl_t               ctl1_q, ctl2_q, ctl3_q, ctl4_q;
  logic signed [15:0] g1_q [4];
  logic [WW-1:0]      w1_q [4];
  logic signed [15:0] near2_q, near3_q;
  logic signed [PW-1:0] m2_q [4];
  logic signed [PW:0]   sa3_q, sb3_q;
  logic signed [15:0]   value4_q;

  logic signed [TW-1:0] tot, rnd, sh;
  logic signed [15:0]   sat, value_d;

  // corners: 0 (i1,j1), 1 (i2,j1), 2 (i1,j2), 3 (i2,j2)
  always_comb begin
    g[0] = rpar_i ? rd_i[1] : rd_i[0];
    g[1] = rpar_i ? rd_i[3] : rd_i[2];
    g[2] = rpar_i ? rd_i[0] : rd_i[1];
    g[3] = rpar_i ? rd_i[2] : rd_i[3];
    pw   = {1'b0, p_i};
    qw   = {1'b0, q_i};
    pn   = ONE - pw;
    qn   = ONE - qw;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      ctl1_q  <= ctl_i;
      g1_q    <= g;
      w1_q[0] <= WW'(pn) * WW'(qn);
      w1_q[1] <= WW'(pw) * WW'(qn);
      w1_q[2] <= WW'(pn) * WW'(qw);
      w1_q[3] <= WW'(pw) * WW'(qw);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      ctl2_q  <= ctl1_q;
      near2_q <= g1_q[0];
      for (int k = 0; k < 4; k++) begin
        m2_q[k] <= PW'($signed({1'b0, w1_q[k]})) * PW'(g1_q[k]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      ctl3_q  <= ctl2_q;
      near3_q <= near2_q;
      sa3_q   <= (PW+1)'(m2_q[0]) + (PW+1)'(m2_q[1]);
      sb3_q   <= (PW+1)'(m2_q[2]) + (PW+1)'(m2_q[3]);
    end
  end

  always_comb begin
    tot = TW'(sa3_q) + TW'(sb3_q);
    rnd = tot + HALF;
    sh  = rnd >>> (2 * WEIGHT_BITS);
    if (sh > VMAX) begin
      sat = 16'sh7FFF;
    end else if (sh < VMIN) begin
      sat = -16'sh8000;
    end else begin
      sat = 16'(sh);
    end
    value_d = '0;
    if (ctl3_q.status == ST_OK) begin
      case (ctl3_q.kind)
        KIND_NEAREST:  value_d = near3_q;
        KIND_BILINEAR: value_d = sat;
        default:       value_d = '0;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      ctl4_q   <= ctl3_q;
      value4_q <= value_d;
    end
  end

  assign value_o  = value4_q;
  assign status_o = ctl4_q.status;

endmodule

>>> src/glu_checker.sv
// port-level checker for the grid field lookup and its bind
module glu_checker import glu_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input out_t out_data_o
);

  // a waiting result stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // input only backs up when the whole pipeline is full behind a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled with room in the pipeline");

  // errors carry a zero value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != ST_OK |-> out_data_o.value == 16'sd0)
    else $error("nonzero value with error status");

  // no unused status code
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.status == ST_OK || out_data_o.status == ST_LON
                    || out_data_o.status == ST_LAT)
    else $error("undefined status code");

  // an empty pipeline frees the input at once
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("stall with no result pending");

endmodule

bind grid_field_bilinear_lookup glu_checker u_glu_checker (.*);

>>> tb/tb_grid_field_bilinear_lookup.sv
// self-checking testbench of the grid field lookup: random and directed queries against a local predictor
module tb_grid_field_bilinear_lookup;
  import glu_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] KIND_SPARE = 2'd3;
  localparam int LON_N = LON_MAX_CELLS_DEF;
  localparam int LAT_N = LAT_MAX_CELLS_DEF;
  localparam int WB = WEIGHT_BITS_DEF;
  localparam int SETTLE_CYCLES = 24;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  in_t         in_data_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_t        out_data_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  grid_field_bilinear_lookup dut (.*);

  in_t  pending_items[$];
  out_t expected_results[$];
  logic signed [15:0] grid_mirror [LON_N][LAT_N];
  bit   written [LON_N][LAT_N];
  int   miss_c[$], miss_r[$];
  int   items_queued = 0;
  int   lon_org, lon_sp, lon_cnt, lat_org, lat_sp, lat_cnt;
  int   errors = 0;
  bit   in_fire, out_fire;
  int   in_gap = 0, out_hold = 0;
  bit   in_busy = 1'b0, out_busy = 1'b0;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #8_000_000;
    $display("tb_grid_field_bilinear_lookup: done, errors");
    $finish;
  end

  task automatic report_mismatch(string what, int got, int want);
    errors++;
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
  endtask

  // entries not yet written are noted so they can be filled first
  function automatic logic signed [15:0] read_cell(int c, int r);
    if (!written[c][r]) begin
      miss_c.push_back(c);
      miss_r.push_back(r);
    end
    return grid_mirror[c][r];
  endfunction

  function automatic out_t predict_result(in_t it);
    out_t r;
    longint d, o, t, ci, ri, i1, i2, j1, j2, p, q, pn, qn, sum, v;
    int ncol, nrow;
    r = '0;
    ncol = lon_cnt < LON_N ? lon_cnt : LON_N;
    nrow = lat_cnt < LAT_N ? lat_cnt : LAT_N;
    d = (longint'(it.longitude) - lon_org) & 64'hffff;
    o = longint'(it.latitude) - lat_org;
    r.status = ST_OK;
    if (it.kind == KIND_WRITE) begin
      grid_mirror[it.column][it.row] = it.sample;
      written[it.column][it.row] = 1'b1;
    end else if (it.kind == KIND_NEAREST) begin
      t = 2 * o + lat_sp;
      if (lon_sp == 0) r.status = ST_LON;
      else begin
        ci = (2 * d + lon_sp) / (2 * lon_sp);
        if (ci >= ncol) r.status = ST_LON;
      end
      if (r.status == ST_OK) begin
        if (lat_sp == 0 || t < 0) r.status = ST_LAT;
        else begin
          ri = t / (2 * lat_sp);
          if (ri >= nrow) r.status = ST_LAT;
        end
      end
      if (r.status == ST_OK) r.value = read_cell(int'(ci), int'(ri));
    end else if (it.kind == KIND_BILINEAR) begin
      p = 0;
      q = 0;
      if (lon_sp == 0) r.status = ST_LON;
      else begin
        i1 = d / lon_sp;
        if (i1 >= ncol) r.status = ST_LON;
        else begin
          i2 = i1 + 1;
          if (i2 >= ncol) begin
            if (d + lon_sp >= 65536) i2 = 0;
            else r.status = ST_LON;
          end
          p = ((d - i1 * lon_sp) << WB) / lon_sp;
        end
      end
      if (r.status == ST_OK) begin
        if (lat_sp == 0 || o < 0) r.status = ST_LAT;
        else begin
          j1 = o / lat_sp;
          j2 = j1 + 1;
          if (j2 >= nrow) r.status = ST_LAT;
          else q = ((o - j1 * lat_sp) << WB) / lat_sp;
        end
      end
      if (r.status == ST_OK) begin
        pn = (64'sd1 << WB) - p;
        qn = (64'sd1 << WB) - q;
        sum = pn * qn * read_cell(int'(i1), int'(j1))
            + p * qn * read_cell(int'(i2), int'(j1))
            + pn * q * read_cell(int'(i1), int'(j2))
            + p * q * read_cell(int'(i2), int'(j2));
        v = (sum + (64'sd1 << (2 * WB - 1))) >>> (2 * WB);
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        r.value = 16'(v);
      end
    end
    return r;
  endfunction

  task automatic push_item(in_t it);
    expected_results.push_back(predict_result(it));
    pending_items.push_back(it);
    items_queued++;
  endtask

  // a lookup that would touch unwritten entries gets them written first
  task automatic queue_item(in_t it);
    int  mc[$], mr[$];
    in_t w;
    miss_c.delete();
    miss_r.delete();
    void'(predict_result(it));
    mc = miss_c;
    mr = miss_r;
    foreach (mc[k]) begin
      if (!written[mc[k]][mr[k]]) begin
        w = '0;
        w.kind = KIND_WRITE;
        w.column = 8'(mc[k]);
        w.row = 7'(mr[k]);
        w.sample = 16'($urandom);
        push_item(w);
      end
    end
    push_item(it);
  endtask

  task automatic queue_query(logic [1:0] kind, int lon, int lat);
    in_t it;
    it = in_t'(65'({$urandom, $urandom}));
    it.kind = kind;
    it.longitude = 16'(lon);
    it.latitude = 16'(lat);
    queue_item(it);
  endtask

  task automatic queue_random_item();
    int sel, lon, lat;
    in_t it;
    sel = $urandom_range(0, 99);
    it = in_t'(65'({$urandom, $urandom}));
    if (sel < 12) begin
      it.kind = KIND_WRITE;
      queue_item(it);
    end else if (sel < 16) begin
      it.kind = KIND_SPARE;
      queue_item(it);
    end else begin
      if ($urandom_range(0, 9) < 8)
        lon = lon_org + $urandom_range(0, lon_cnt + 1) * lon_sp
            + (lon_sp > 0 ? $urandom_range(0, lon_sp - 1) : 0);
      else lon = $urandom;
      if ($urandom_range(0, 9) < 8)
        lat = lat_org + $urandom_range(0, lat_cnt + 1) * lat_sp
            + (lat_sp > 0 ? $urandom_range(0, lat_sp - 1) : 0);
      else lat = $urandom_range(0, 32768) - 16384;
      if (lat > 16384) lat = 16384;
      if (lat < -16384) lat = -16384;
      queue_query(sel < 58 ? KIND_BILINEAR : KIND_NEAREST, lon, lat);
    end
  endtask

  task automatic wait_idle();
    while (pending_items.size() != 0 || expected_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_register(logic [2:0] idx, int value);
    @(negedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= 32'(value);
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_LON_ORIGIN:  lon_org = value & 16'hffff;
      REG_LON_SPACING: lon_sp = value & 16'hffff;
      REG_LON_CELLS:   lon_cnt = value & 9'h1ff;
      REG_LAT_ORIGIN:  lat_org = int'(signed'(16'(value)));
      REG_LAT_SPACING: lat_sp = value & 16'hffff;
      REG_LAT_CELLS:   lat_cnt = value & 8'hff;
      default: ;
    endcase
  endtask

  task automatic run_phase(int lo, int ls, int lc, int ao, int as, int ac, int count);
    int start;
    wait_idle();
    write_register(REG_LON_ORIGIN, lo);
    write_register(REG_LON_SPACING, ls);
    write_register(REG_LON_CELLS, lc);
    write_register(REG_LAT_ORIGIN, ao);
    write_register(REG_LAT_SPACING, as);
    write_register(REG_LAT_CELLS, ac);
    start = items_queued;
    while (items_queued - start < count) queue_random_item();
  endtask

  initial begin
    in_t it;
    lon_org = LON_ORIGIN_RST;
    lon_sp = LON_SPACING_RST;
    lon_cnt = LON_CELLS_RST;
    lat_org = int'(signed'(LAT_ORIGIN_RST));
    lat_sp = LAT_SPACING_RST;
    lat_cnt = LAT_CELLS_RST;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // extreme samples at a few corners
    it = '0;
    it.kind = KIND_WRITE;
    it.column = 8'd0;
    it.row = 7'd0;
    it.sample = 16'sh7fff;
    queue_item(it);
    it.column = 8'd255;
    it.row = 7'd0;
    it.sample = 16'sh8000;
    queue_item(it);

    // directed
    it = '0;
    it.kind = KIND_WRITE;
    it.column = 8'd255;
    it.row = 7'd127;
    it.sample = 16'sh8000;
    queue_item(it);
    it.column = 8'd1;
    it.row = 7'd1;
    it.sample = 16'sh7fff;
    queue_item(it);
    queue_query(KIND_SPARE, 0, 0);
    queue_query(KIND_NEAREST, 0, -16384);
    queue_query(KIND_NEAREST, 128, -16384 + 128);
    queue_query(KIND_NEAREST, 127, -16384 + 127);
    queue_query(KIND_NEAREST, 65535, 16384);
    queue_query(KIND_NEAREST, 65408, 16000);
    queue_query(KIND_NEAREST, 65407, 0);
    queue_query(KIND_BILINEAR, 0, -16384);
    queue_query(KIND_BILINEAR, 200, -16384 + 100);
    queue_query(KIND_BILINEAR, 65535, 0);
    queue_query(KIND_BILINEAR, 65300, -16384 + 300);
    queue_query(KIND_BILINEAR, 300, 16128);
    queue_query(KIND_BILINEAR, 300, 16127);
    queue_query(KIND_BILINEAR, 300, 16384);
    queue_query(KIND_BILINEAR, 32768, -1);

    run_phase(LON_ORIGIN_RST, LON_SPACING_RST, LON_CELLS_RST,
              int'(signed'(LAT_ORIGIN_RST)), LAT_SPACING_RST, LAT_CELLS_RST, 100);
    run_phase(65535, 65535, 1, 16384, 32768, 1, 60);
    run_phase(32768, 1, 256, -16384, 1, 128, 60);
    run_phase(12345, 300, 511, -100, 200, 255, 80);
    run_phase(0, 1024, 64, -16384, 256, 128, 80);
    run_phase(1000, 256, 0, 0, 256, 0, 50);
    run_phase(0, 0, 100, -16384, 256, 100, 50);
    run_phase(0, 256, 100, -16384, 0, 100, 50);
    run_phase(16384, 100, 200, 10000, 50, 2, 60);
    for (int k = 0; k < 6; k++) begin
      run_phase($urandom_range(0, 65535), $urandom_range(1, 2000), $urandom_range(1, 300),
                $urandom_range(0, 32768) - 16384, $urandom_range(1, 2000),
                $urandom_range(1, 140), 70);
    end

    wait_idle();
    if (errors == 0) $display("tb_grid_field_bilinear_lookup: done, clean");
    else $display("tb_grid_field_bilinear_lookup: done, errors");
    $finish;
  end

  always @(posedge clk_i) begin
    in_fire <= in_valid_i && !in_stall_o;
    out_fire <= out_valid_o && !out_stall_i;
  end

  // driver
  always @(negedge clk_i) begin
    if (rst_ni && !(in_valid_i && !in_fire)) begin
      if (in_gap > 0) begin
        in_valid_i <= 1'b0;
        in_gap <= in_gap - 1;
      end else if (pending_items.size() != 0) begin
        in_valid_i <= 1'b1;
        in_data_i <= pending_items.pop_front();
        if ($urandom_range(0, 63) == 0) in_busy <= ~in_busy;
        in_gap <= in_busy ? $urandom_range(0, 7) : 0;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_fire) begin
        if ($urandom_range(0, 63) == 0) out_busy <= ~out_busy;
        out_hold = out_busy ? $urandom_range(0, 7) : 0;
      end
      out_stall_i <= out_hold > 0;
      if (out_hold > 0) out_hold--;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected transfer, value", out_data_o.value, 0);
      end else begin
        want = expected_results.pop_front();
        if (out_data_o.status !== want.status)
          report_mismatch("status", out_data_o.status, want.status);
        if (out_data_o.value !== want.value)
          report_mismatch("value", out_data_o.value, want.value);
      end
    end
  end

endmodule
